### sv/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, style codes, character constants, word tables and helper
// functions for the STIL token classifier.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int WORD_CMP_LEN   = 16;
    localparam int MAX_RUNS       = 4;
    localparam int RUN_FIFO_DEPTH = 8;

    typedef logic [WORD_CMP_LEN-1:0][7:0] word_t;

    localparam logic [3:0] ST_DEFAULT  = 4'd0;
    localparam logic [3:0] ST_COMMENT  = 4'd1;
    localparam logic [3:0] ST_STRING   = 4'd2;
    localparam logic [3:0] ST_UNIT     = 4'd3;
    localparam logic [3:0] ST_NAME     = 4'd4;
    localparam logic [3:0] ST_NUMBER   = 4'd5;
    localparam logic [3:0] ST_BLOCK    = 4'd6;
    localparam logic [3:0] ST_KEYWORD  = 4'd7;
    localparam logic [3:0] ST_EVENT    = 4'd8;
    localparam logic [3:0] ST_OPERATOR = 4'd9;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EXP_LO = 8'h65;
    localparam logic [7:0] CH_EXP_UP = 8'h45;

    typedef enum logic [13:0] {
        TK_NONE  = 14'b00000000000001,
        TK_SLASH = 14'b00000000000010,
        TK_DOT   = 14'b00000000000100,
        TK_LCOM  = 14'b00000000001000,
        TK_BLOCK = 14'b00000000010000,
        TK_SPACE = 14'b00000000100000,
        TK_QUOTE = 14'b00000001000000,
        TK_NINT  = 14'b00000010000000,
        TK_NFRAC = 14'b00000100000000,
        TK_NE    = 14'b00001000000000,
        TK_NES   = 14'b00010000000000,
        TK_NEXP  = 14'b00100000000000,
        TK_IDENT = 14'b01000000000000,
        TK_EOL   = 14'b10000000000000
    } kind_t;

    // cls: style comes from the word classifier
    typedef struct packed {
        logic [3:0]  style;
        logic [15:0] len;
        logic        cls;
    } slot_t;

    typedef struct packed {
        logic [2:0]               n;
        slot_t [MAX_RUNS-1:0]     slot;
    } emits_t;

    typedef struct packed {
        logic [3:0]  run_style;
        logic [15:0] run_length;
        logic        last_of_item;
    } run_t;

    typedef struct packed {
        logic [2:0]           count;
        run_t [MAX_RUNS-1:0]  runs;
    } push_t;

    localparam logic [127:0] BLOCK_WORDS [25] = '{
        "STIL", "Header", "Signals", "SignalGroups", "Timing", "WaveformTable",
        "Waveforms", "PatternBurst", "PatList", "PatternExec", "Pattern", "Patterns",
        "Procedures", "MacroDefs", "ScanStructures", "Spec", "Selector", "Category",
        "DomainGroups", "Domains", "Combinational", "Vector", "TimingList",
        "WaveformCharList", "Procedure"
    };

    localparam logic [127:0] KEY_WORDS [36] = '{
        "In", "Out", "InOut", "Supply", "Bidirectional", "Title", "Date", "Source",
        "History", "Period", "W", "V", "B", "Annotate", "Lo", "Hi", "Alignment",
        "Terminate", "Based", "Default", "WaveformChar", "Domain", "Argument", "Value",
        "ScanIn", "ScanOut", "ScanInOut", "ScanEnable", "ScanMode", "Event",
        "Terminations", "BitType", "Range", "Min", "Max", "Scale"
    };

    localparam logic [7:0] EVENT_LETTERS [10] = '{
        "D", "U", "Z", "X", "N", "T", "L", "H", "P", "p"
    };

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_sign(logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_id_start(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_id_char(logic [7:0] c);
        return is_id_start(c) || is_digit(c);
    endfunction

    function automatic emits_t push_run(emits_t e_in, logic [3:0] s, logic [15:0] l,
                                        logic cl);
        emits_t e;
        e = e_in;
        if ((l != 16'd0) && (e.n < 3'(MAX_RUNS)))
        begin
            e.slot[e.n[1:0]] = '{style: s, len: l, cls: cl};
            e.n = e.n + 3'd1;
        end
        return e;
    endfunction

    function automatic logic [3:0] quote_style(logic [3:0] q);
        if (q[3])
        begin
            return ST_STRING;
        end
        return (q[1:0] == 2'd2) ? ST_UNIT : ST_NAME;
    endfunction

    function automatic logic [3:0] kind_style(kind_t k, logic ibc, logic [3:0] q);
        logic [3:0] s;
        case (k)
            TK_SPACE: s = ST_DEFAULT;
            TK_LCOM, TK_BLOCK: s = ST_COMMENT;
            TK_QUOTE: s = quote_style(q);
            TK_NINT, TK_NFRAC, TK_NE, TK_NES, TK_NEXP: s = ST_NUMBER;
            TK_IDENT: s = ST_DEFAULT;
            TK_EOL: s = ibc ? ST_COMMENT : ST_DEFAULT;
            default: s = ST_OPERATOR;
        endcase
        return s;
    endfunction

    // literals are right-justified, first character in the highest used byte
    function automatic logic word_is(word_t w, logic [4:0] len, logic [127:0] lit);
        int   lit_len;
        logic hit;
        lit_len = 0;
        for (int j = 0; j < WORD_CMP_LEN; j++)
        begin
            if (lit[8*j +: 8] != 8'd0)
            begin
                lit_len++;
            end
        end
        hit = (int'(len) == lit_len);
        for (int i = 0; i < WORD_CMP_LEN; i++)
        begin
            if (i < lit_len)
            begin
                if (w[i] != lit[8*(lit_len-1-i) +: 8])
                begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    // len of zero means no word or a word too long to match
    function automatic logic [3:0] classify_word(word_t w, logic [4:0] len);
        logic [3:0] r;
        r = ST_DEFAULT;
        if (len == 5'd1)
        begin
            for (int k = 0; k < 10; k++)
            begin
                if (w[0] == EVENT_LETTERS[k])
                begin
                    r = ST_EVENT;
                end
            end
        end
        for (int k = 0; k < 36; k++)
        begin
            if (word_is(w, len, KEY_WORDS[k]))
            begin
                r = ST_KEYWORD;
            end
        end
        for (int k = 0; k < 25; k++)
        begin
            if (word_is(w, len, BLOCK_WORDS[k]))
            begin
                r = ST_BLOCK;
            end
        end
        if (len == 5'd0)
        begin
            r = ST_DEFAULT;
        end
        return r;
    endfunction

endpackage

### sv/stc_if.sv
// ----------------------------------------------------------------------------
// stc_if
// Valid/ready channels of the STIL token classifier: source bytes in,
// style runs out.
// ----------------------------------------------------------------------------
interface stc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_line_break;
    logic       end_of_span;

    modport source (output valid, ch, is_line_break, end_of_span, input ready);
    modport sink   (input valid, ch, is_line_break, end_of_span, output ready);
endinterface

interface stc_run_if;
    logic        valid;
    logic        ready;
    logic [3:0]  run_style;
    logic [15:0] run_length;
    logic        last_of_item;

    modport source (output valid, run_style, run_length, last_of_item, input ready);
    modport sink   (input valid, run_style, run_length, last_of_item, output ready);
endinterface

### sv/stc_lexer.sv
// ----------------------------------------------------------------------------
// stc_lexer
// Input register plus the one-pass lexer step: updates the token state and
// produces up to four style runs per byte transfer.
// ----------------------------------------------------------------------------
module stc_lexer #(
    parameter int MAX_WORD_LEN = 16,
    parameter int RUN_LEN_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    stc_byte_if.sink          byte_in,
    input  logic              space_ok,
    output stc_pkg::push_t    push
);

    localparam int RC_W = (RUN_LEN_BITS >= 16) ? 16 : RUN_LEN_BITS;
    localparam int WL_W = $clog2(MAX_WORD_LEN + 2);
    localparam logic [RC_W:0] RUN_LIMIT = {1'b0, {RC_W{1'b1}}};

    logic               in_v_reg, in_v_next;
    logic [7:0]         ch_reg;
    logic               lb_reg;
    logic               eos_reg;
    logic               accept;
    logic               fire;

    stc_pkg::kind_t     kind_reg;
    logic [RC_W-1:0]    rc_reg;
    logic               star_reg;
    logic               ibc_reg;
    logic [3:0]         qinfo_reg;
    logic [WL_W-1:0]    wlen_reg;
    logic [7:0]         held_reg;
    stc_pkg::word_t     wbuf_reg;

    stc_pkg::kind_t     k;
    logic [RC_W-1:0]    rc;
    logic               st;
    logic               ibc;
    logic [3:0]         q;
    logic [WL_W-1:0]    wl;
    logic [7:0]         h0;
    stc_pkg::word_t     wb;
    stc_pkg::emits_t    e;
    logic [7:0]         c;
    logic               ends;
    logic               closing;
    logic [1:0]         ph;
    logic               lead;
    logic [4:0]         cls_len;
    logic [3:0]         cls_style;

    function automatic stc_pkg::emits_t add_run(
        input  stc_pkg::emits_t e_in,
        input  logic [RC_W-1:0] rc_in,
        input  logic [1:0]      inc,
        input  logic [3:0]      s,
        input  logic            cl,
        output logic [RC_W-1:0] rc_out
    );
        logic [RC_W:0]   sum;
        stc_pkg::emits_t eo;
        eo  = e_in;
        sum = {1'b0, rc_in} + {{(RC_W-1){1'b0}}, inc};
        if (sum >= RUN_LIMIT)
        begin
            eo     = stc_pkg::push_run(eo, s, 16'(RUN_LIMIT), cl);
            rc_out = RC_W'(sum - RUN_LIMIT);
        end
        else
        begin
            rc_out = sum[RC_W-1:0];
        end
        return eo;
    endfunction

    assign fire          = in_v_reg && space_ok;
    assign byte_in.ready = !in_v_reg || fire;
    assign accept        = byte_in.valid && byte_in.ready;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (accept)
        begin
            in_v_next = 1'b1;
        end
        else if (fire)
        begin
            in_v_next = 1'b0;
        end
    end

    always_comb
    begin
        k       = kind_reg;
        rc      = rc_reg;
        st      = star_reg;
        ibc     = ibc_reg;
        q       = qinfo_reg;
        wl      = wlen_reg;
        h0      = held_reg;
        wb      = wbuf_reg;
        e       = '0;
        c       = ch_reg;
        ends    = 1'b0;
        closing = 1'b0;
        ph      = 2'd0;
        lead    = 1'b0;

        if (eos_reg || lb_reg)
        begin
            if (!eos_reg && (kind_reg == stc_pkg::TK_EOL) && (c == stc_pkg::CH_LF))
            begin
                // CR LF pair is one run
                e  = stc_pkg::push_run(e, ibc ? stc_pkg::ST_COMMENT : stc_pkg::ST_DEFAULT,
                                       16'd2, 1'b0);
                k  = stc_pkg::TK_NONE;
                rc = '0;
                st = 1'b0;
            end
            else
            begin
                case (k)
                    stc_pkg::TK_NONE:
                    begin
                    end
                    stc_pkg::TK_NE:
                    begin
                        e = stc_pkg::push_run(e, stc_pkg::ST_NUMBER, 16'(rc), 1'b0);
                        e = stc_pkg::push_run(e, stc_pkg::ST_DEFAULT, 16'd1, 1'b0);
                    end
                    stc_pkg::TK_NES:
                    begin
                        e = stc_pkg::push_run(e, stc_pkg::ST_NUMBER, 16'(rc), 1'b0);
                        e = stc_pkg::push_run(e, stc_pkg::ST_DEFAULT, 16'd1, 1'b0);
                        e = stc_pkg::push_run(e, stc_pkg::ST_OPERATOR, 16'd1, 1'b0);
                    end
                    stc_pkg::TK_IDENT:
                    begin
                        e = stc_pkg::push_run(e, stc_pkg::ST_DEFAULT, 16'(rc), 1'b1);
                    end
                    default:
                    begin
                        e = stc_pkg::push_run(e, stc_pkg::kind_style(k, ibc, q), 16'(rc), 1'b0);
                    end
                endcase
                k  = stc_pkg::TK_NONE;
                rc = '0;
                st = 1'b0;
                if (!eos_reg)
                begin
                    if (c == stc_pkg::CH_CR)
                    begin
                        k  = stc_pkg::TK_EOL;
                        rc = RC_W'(1);
                    end
                    else
                    begin
                        e = stc_pkg::push_run(e, ibc ? stc_pkg::ST_COMMENT : stc_pkg::ST_DEFAULT,
                                              16'd1, 1'b0);
                    end
                end
            end
        end
        else
        begin
            // broken exponent: close the number, relex the held bytes
            if (((k == stc_pkg::TK_NE) && !(stc_pkg::is_sign(c) || stc_pkg::is_digit(c))) ||
                ((k == stc_pkg::TK_NES) && !stc_pkg::is_digit(c)))
            begin
                e = stc_pkg::push_run(e, stc_pkg::ST_NUMBER, 16'(rc), 1'b0);
                if (k == stc_pkg::TK_NE)
                begin
                    k     = stc_pkg::TK_IDENT;
                    rc    = RC_W'(1);
                    wb[0] = h0;
                    wl    = WL_W'(1);
                end
                else
                begin
                    e  = stc_pkg::push_run(e, stc_pkg::ST_DEFAULT, 16'd1, 1'b0);
                    e  = stc_pkg::push_run(e, stc_pkg::ST_OPERATOR, 16'd1, 1'b0);
                    k  = stc_pkg::TK_NONE;
                    rc = '0;
                end
                st = 1'b0;
            end

            if (k == stc_pkg::TK_EOL)
            begin
                e  = stc_pkg::push_run(e, ibc ? stc_pkg::ST_COMMENT : stc_pkg::ST_DEFAULT,
                                       16'(rc), 1'b0);
                k  = stc_pkg::TK_NONE;
                rc = '0;
                st = 1'b0;
            end

            case (k)
                stc_pkg::TK_SLASH: ends = (c != stc_pkg::CH_SLASH) && (c != stc_pkg::CH_STAR);
                stc_pkg::TK_DOT:   ends = !stc_pkg::is_digit(c);
                stc_pkg::TK_SPACE: ends = !stc_pkg::is_space(c);
                stc_pkg::TK_NINT:  ends = !stc_pkg::is_digit(c) && (c != stc_pkg::CH_DOT) &&
                                          (c != stc_pkg::CH_EXP_LO) && (c != stc_pkg::CH_EXP_UP);
                stc_pkg::TK_NFRAC: ends = !stc_pkg::is_digit(c) &&
                                          (c != stc_pkg::CH_EXP_LO) && (c != stc_pkg::CH_EXP_UP);
                stc_pkg::TK_NEXP:  ends = !stc_pkg::is_digit(c);
                stc_pkg::TK_IDENT: ends = !stc_pkg::is_id_char(c);
                default:           ends = 1'b0;
            endcase

            if (ends)
            begin
                e  = stc_pkg::push_run(e, stc_pkg::kind_style(k, ibc, q), 16'(rc),
                                       k == stc_pkg::TK_IDENT);
                k  = stc_pkg::TK_NONE;
                rc = '0;
                st = 1'b0;
            end

            if ((k == stc_pkg::TK_NONE) && ibc)
            begin
                k  = stc_pkg::TK_BLOCK;
                rc = '0;
                st = 1'b0;
            end

            case (k)
                stc_pkg::TK_NONE:
                begin
                    rc = RC_W'(1);
                    if (c == stc_pkg::CH_SLASH)
                    begin
                        k = stc_pkg::TK_SLASH;
                    end
                    else if (stc_pkg::is_space(c))
                    begin
                        k = stc_pkg::TK_SPACE;
                    end
                    else if ((c == stc_pkg::CH_SQUOTE) || (c == stc_pkg::CH_DQUOTE))
                    begin
                        k = stc_pkg::TK_QUOTE;
                        q = (c == stc_pkg::CH_DQUOTE) ? 4'b1000 : 4'b0000;
                    end
                    else if (stc_pkg::is_digit(c))
                    begin
                        k = stc_pkg::TK_NINT;
                    end
                    else if (c == stc_pkg::CH_DOT)
                    begin
                        k = stc_pkg::TK_DOT;
                    end
                    else if (stc_pkg::is_id_start(c))
                    begin
                        k     = stc_pkg::TK_IDENT;
                        wb[0] = c;
                        wl    = WL_W'(1);
                    end
                    else
                    begin
                        rc = '0;
                        e  = stc_pkg::push_run(e, stc_pkg::ST_OPERATOR, 16'd1, 1'b0);
                    end
                end
                stc_pkg::TK_SLASH:
                begin
                    if (c == stc_pkg::CH_SLASH)
                    begin
                        k  = stc_pkg::TK_LCOM;
                        rc = RC_W'(2);
                    end
                    else
                    begin
                        e   = stc_pkg::push_run(e, stc_pkg::ST_COMMENT, 16'd2, 1'b0);
                        k   = stc_pkg::TK_NONE;
                        rc  = '0;
                        st  = 1'b0;
                        ibc = 1'b1;
                    end
                end
                stc_pkg::TK_DOT:
                begin
                    k  = stc_pkg::TK_NINT;
                    rc = RC_W'(2);
                end
                stc_pkg::TK_LCOM:
                begin
                    e = add_run(e, rc, 2'd1, stc_pkg::ST_COMMENT, 1'b0, rc);
                end
                stc_pkg::TK_SPACE:
                begin
                    e = add_run(e, rc, 2'd1, stc_pkg::ST_DEFAULT, 1'b0, rc);
                end
                stc_pkg::TK_NEXP:
                begin
                    e = add_run(e, rc, 2'd1, stc_pkg::ST_NUMBER, 1'b0, rc);
                end
                stc_pkg::TK_NINT, stc_pkg::TK_NFRAC:
                begin
                    if (stc_pkg::is_digit(c))
                    begin
                        e = add_run(e, rc, 2'd1, stc_pkg::ST_NUMBER, 1'b0, rc);
                    end
                    else if (c == stc_pkg::CH_DOT)
                    begin
                        k = stc_pkg::TK_NFRAC;
                        e = add_run(e, rc, 2'd1, stc_pkg::ST_NUMBER, 1'b0, rc);
                    end
                    else
                    begin
                        h0 = c;
                        k  = stc_pkg::TK_NE;
                    end
                end
                stc_pkg::TK_BLOCK:
                begin
                    closing = st && (c == stc_pkg::CH_SLASH);
                    st      = (c == stc_pkg::CH_STAR);
                    e       = add_run(e, rc, 2'd1, stc_pkg::ST_COMMENT, 1'b0, rc);
                    if (closing)
                    begin
                        e   = stc_pkg::push_run(e, stc_pkg::ST_COMMENT, 16'(rc), 1'b0);
                        k   = stc_pkg::TK_NONE;
                        rc  = '0;
                        st  = 1'b0;
                        ibc = 1'b0;
                    end
                end
                stc_pkg::TK_QUOTE:
                begin
                    if (c == (q[3] ? stc_pkg::CH_DQUOTE : stc_pkg::CH_SQUOTE))
                    begin
                        e  = add_run(e, rc, 2'd1, stc_pkg::quote_style(q), 1'b0, rc);
                        e  = stc_pkg::push_run(e, stc_pkg::quote_style(q), 16'(rc), 1'b0);
                        k  = stc_pkg::TK_NONE;
                        rc = '0;
                        st = 1'b0;
                    end
                    else
                    begin
                        if (!q[3])
                        begin
                            ph   = q[1:0];
                            lead = stc_pkg::is_digit(c) || (c == stc_pkg::CH_DOT);
                            if (ph == 2'd0)
                            begin
                                ph = stc_pkg::is_sign(c) ? 2'd1 : (lead ? 2'd2 : 2'd3);
                            end
                            else if (ph == 2'd1)
                            begin
                                ph = lead ? 2'd2 : 2'd3;
                            end
                            q = {2'b00, ph};
                        end
                        e = add_run(e, rc, 2'd1, stc_pkg::quote_style(q), 1'b0, rc);
                    end
                end
                stc_pkg::TK_NE:
                begin
                    if (stc_pkg::is_sign(c))
                    begin
                        k = stc_pkg::TK_NES;
                    end
                    else
                    begin
                        k = stc_pkg::TK_NEXP;
                        e = add_run(e, rc, 2'd2, stc_pkg::ST_NUMBER, 1'b0, rc);
                    end
                end
                stc_pkg::TK_NES:
                begin
                    k = stc_pkg::TK_NEXP;
                    e = add_run(e, rc, 2'd3, stc_pkg::ST_NUMBER, 1'b0, rc);
                end
                stc_pkg::TK_IDENT:
                begin
                    if ((wl < WL_W'(MAX_WORD_LEN)) && (wl < WL_W'(stc_pkg::WORD_CMP_LEN)))
                    begin
                        wb[wl[3:0]] = c;
                    end
                    if (wl <= WL_W'(MAX_WORD_LEN))
                    begin
                        wl = wl + WL_W'(1);
                    end
                    e = add_run(e, rc, 2'd1, stc_pkg::ST_DEFAULT, 1'b1, rc);
                end
                default:
                begin
                    k = stc_pkg::TK_NONE;
                end
            endcase
        end

        // words longer than the compare window never match a table entry
        cls_len   = (wl > WL_W'(stc_pkg::WORD_CMP_LEN)) ? 5'd0 : wl[4:0];
        cls_style = stc_pkg::classify_word(wb, cls_len);
    end

    always_comb
    begin
        push.count = fire ? e.n : 3'd0;
        for (int i = 0; i < stc_pkg::MAX_RUNS; i++)
        begin
            push.runs[i].run_style    = e.slot[i].cls ? cls_style : e.slot[i].style;
            push.runs[i].run_length   = e.slot[i].len;
            push.runs[i].last_of_item = (3'(i) == (e.n - 3'd1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            kind_reg  <= stc_pkg::TK_NONE;
            rc_reg    <= '0;
            star_reg  <= 1'b0;
            ibc_reg   <= 1'b0;
            qinfo_reg <= 4'd0;
            wlen_reg  <= '0;
            held_reg  <= 8'd0;
        end
        else
        begin
            in_v_reg <= in_v_next;
            if (fire)
            begin
                kind_reg  <= k;
                rc_reg    <= rc;
                star_reg  <= st;
                ibc_reg   <= ibc;
                qinfo_reg <= q;
                wlen_reg  <= wl;
                held_reg  <= h0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= byte_in.ch;
            lb_reg  <= byte_in.is_line_break;
            eos_reg <= byte_in.end_of_span;
        end
        if (fire)
        begin
            wbuf_reg <= wb;
        end
    end

endmodule

### sv/stc_run_fifo.sv
// ----------------------------------------------------------------------------
// stc_run_fifo
// Run queue: takes up to four runs per cycle from the lexer, hands out one
// run per output transfer.
// ----------------------------------------------------------------------------
module stc_run_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  stc_pkg::push_t    push,
    output logic              space_ok,
    stc_run_if.source         run_out
);

    localparam int PTR_W = $clog2(stc_pkg::RUN_FIFO_DEPTH);

    stc_pkg::run_t      mem [stc_pkg::RUN_FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               pop;

    assign pop      = run_out.valid && run_out.ready;
    assign space_ok = count_reg <= (PTR_W+1)'(stc_pkg::RUN_FIFO_DEPTH - stc_pkg::MAX_RUNS);

    assign run_out.valid        = (count_reg != '0);
    assign run_out.run_style    = mem[rd_ptr_reg].run_style;
    assign run_out.run_length   = mem[rd_ptr_reg].run_length;
    assign run_out.last_of_item = mem[rd_ptr_reg].last_of_item;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < stc_pkg::MAX_RUNS; i++)
        begin
            if (3'(i) < push.count)
            begin
                mem[wr_ptr_reg + PTR_W'(i)] <= push.runs[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/stil_token_classifier.sv
// ----------------------------------------------------------------------------
// stil_token_classifier
// STIL lexer: source bytes in, (style, length) runs out.
// ----------------------------------------------------------------------------
// Takes one byte transfer per clock while the run queue has room. Each byte is
// registered, lexed from that register once the queue has room, and its runs (zero
// to four) are written at once into an eight-entry run queue. The output side moves
// one run per cycle while the sink is ready, so the runs of a byte leave the queue
// one after another. The input takes a byte whenever the queue has at least four
// free entries, which keeps one byte per cycle as long as bytes average no more
// than one run and the sink keeps up.
module stil_token_classifier #(
    parameter int MAX_WORD_LEN = 16,
    parameter int RUN_LEN_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    stc_byte_if.sink    byte_in,
    stc_run_if.source   run_out
);

    stc_pkg::push_t push;
    logic           space_ok;

    stc_lexer #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .RUN_LEN_BITS (RUN_LEN_BITS)
    ) u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .space_ok (space_ok),
        .push     (push)
    );

    stc_run_fifo u_run_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .run_out  (run_out)
    );

endmodule

### sv/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks for the STIL token classifier, bound to the top level.
// ----------------------------------------------------------------------------
module stc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  out_style,
    input logic [15:0] out_length,
    input logic        out_last
);

    // a waiting run holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_style) &&
        $stable(out_length) && $stable(out_last))
        else $error("stalled run changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_length != 16'd0) && (out_style <= 4'd9))
        else $error("bad run payload");

    // all runs of one byte are queued together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("gap inside runs of one byte");

    // an empty queue refills only from a byte that was taken, registered and lexed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("run without source byte");

endmodule

bind stil_token_classifier stc_checker u_stc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .out_valid  (run_out.valid),
    .out_ready  (run_out.ready),
    .out_style  (run_out.run_style),
    .out_length (run_out.run_length),
    .out_last   (run_out.last_of_item)
);
